// ----- hdl/rpbht_pkg.sv -----
// Shared codes, widths and types for the render pass batch hazard tracker.
`default_nettype none
package rpbht_pkg;

    localparam int ID_W   = 16;
    localparam int CNT_W  = 20;
    localparam int BUD_W  = 24;
    localparam int TOT_W  = 25;
    localparam int SUM_W  = 26;
    localparam int KIND_W = 2;
    localparam int RUNO_W = 4;
    localparam int ACT_W  = 2;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [BUD_W-1:0]  t_budget;
    typedef logic [TOT_W-1:0]  t_total;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [RUNO_W-1:0] t_run_out;
    typedef logic [ACT_W-1:0]  t_action;

    localparam t_action ACT_ENQUEUE = 2'd0;
    localparam t_action ACT_EMIT    = 2'd1;
    localparam t_action ACT_CLEAR   = 2'd2;

    localparam t_kind KIND_QUEUED = 2'd0;
    localparam t_kind KIND_FLUSH  = 2'd1;
    localparam t_kind KIND_EMIT   = 2'd2;
    localparam t_kind KIND_DONE   = 2'd3;

    localparam logic CFG_VERTEX_BUDGET = 1'b0;
    localparam logic CFG_INDEX_BUDGET  = 1'b1;

    localparam t_budget VERTEX_BUDGET_RST = 24'd65536;
    localparam t_budget INDEX_BUDGET_RST  = 24'd262144;

    // Hazard flags gathered by the run and sampled-id scans.
    typedef struct packed {
        logic hazard;     // texture or palette is a live attachment
        logic found;      // run with same colour/depth pair exists
        logic att;        // colour or depth target is some run's attachment
        logic samp_rtds;  // colour or depth target already sampled
        logic samp_tex;   // texture already in sampled set
        logic samp_pal;   // palette already in sampled set
    } t_scan_flags;

endpackage
`default_nettype wire

// ----- hdl/rpbht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpbht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/render_pass_batch_hazard_tracker.sv -----
// Top level of the render pass batch hazard tracker: sequencer, run table and scans.
`default_nettype none
// Enqueue: one comparator walks the run table, then the sampled-id RAM read port, and
//   then the single result word follows. A zero colour target is refused straight from idle.
// Emit: the draw-record RAM read port walks every draw once per run, one word out per
//   matching draw, then the done word. Clear: a single done word.
// One item at a time; busy is high from acceptance until the edge that registers the last
//   word, so the next command may be taken while that word is on the ports.
// Results appear on o_strobe for one cycle each; the receiver cannot stall them.
// Reset (i_rst_n low, synchronous) empties all tables and restores the two budgets.
module render_pass_batch_hazard_tracker #(
    parameter int RUN_SLOTS     = 8,
    parameter int SAMPLED_SLOTS = 16,
    parameter int DRAW_SLOTS    = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire rpbht_pkg::t_action   i_action,
    input  wire rpbht_pkg::t_id       i_draw_tag,
    input  wire rpbht_pkg::t_id       i_color_target,
    input  wire rpbht_pkg::t_id       i_depth_target,
    input  wire rpbht_pkg::t_id       i_texture_id,
    input  wire rpbht_pkg::t_id       i_palette_id,
    input  wire rpbht_pkg::t_cnt      i_vertex_count,
    input  wire rpbht_pkg::t_cnt      i_index_count,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire rpbht_pkg::t_budget   i_cfg_data,
    // result words
    output logic                      o_strobe,
    output rpbht_pkg::t_kind          o_kind,
    output rpbht_pkg::t_id            o_out_tag,
    output rpbht_pkg::t_run_out       o_out_run,
    output logic                      o_last
);
    import rpbht_pkg::*;

    localparam int RUN_AW  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RUN_CW  = $clog2(RUN_SLOTS + 1);
    localparam int SAMP_AW = (SAMPLED_SLOTS > 1) ? $clog2(SAMPLED_SLOTS) : 1;
    localparam int SAMP_CW = $clog2(SAMPLED_SLOTS + 1);
    localparam int DRAW_AW = (DRAW_SLOTS > 1) ? $clog2(DRAW_SLOTS) : 1;
    localparam int DRAW_CW = $clog2(DRAW_SLOTS + 1);
    localparam int REC_W   = ID_W + RUN_AW;

    localparam logic [RUN_CW-1:0]  RUN_FULL  = RUN_CW'(RUN_SLOTS);
    localparam logic [SAMP_CW-1:0] SAMP_FULL = SAMP_CW'(SAMPLED_SLOTS);
    localparam logic [DRAW_CW-1:0] DRAW_FULL = DRAW_CW'(DRAW_SLOTS);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RUNS = 4'd1;  // walk run table
    localparam logic [3:0] S_SAMP = 4'd2;  // walk sampled-id RAM
    localparam logic [3:0] S_DEC  = 4'd3;  // hazards, run lookup/creation, draw table room
    localparam logic [3:0] S_VTX  = 4'd4;  // vertex budget
    localparam logic [3:0] S_IDX  = 4'd5;  // index budget
    localparam logic [3:0] S_TEX  = 4'd6;  // note texture
    localparam logic [3:0] S_PAL  = 4'd7;  // note palette, record draw
    localparam logic [3:0] S_EMIT = 4'd8;  // list draws run by run

    // control state
    logic [3:0]         r_state,      n_state;
    logic [RUN_CW-1:0]  r_ridx,       n_ridx;
    logic [SAMP_CW-1:0] r_sidx,       n_sidx;
    logic [DRAW_CW-1:0] r_didx,       n_didx;
    logic               r_pend,       n_pend;
    logic [RUN_AW-1:0]  r_pend_run,   n_pend_run;
    t_scan_flags        r_flags,      n_flags;
    logic [RUN_AW-1:0]  r_run_sel,    n_run_sel;
    logic [RUN_CW-1:0]  r_run_count,  n_run_count;
    logic [SAMP_CW-1:0] r_samp_count, n_samp_count;
    logic [DRAW_CW-1:0] r_q_count,    n_q_count;
    t_total             r_vtot,       n_vtot;
    t_total             r_itot,       n_itot;
    t_budget            r_vbudget,    n_vbudget;
    t_budget            r_ibudget,    n_ibudget;
    logic               r_strobe,     n_strobe;
    t_kind              r_kind,       n_kind;
    t_id                r_tag_out,    n_tag_out;
    t_run_out           r_run_out,    n_run_out;
    logic               r_last,       n_last;

    // current command word (payload, no reset)
    t_id  r_tag, r_rt, r_ds, r_tex, r_pal;
    t_cnt r_nv, r_ni;

    // run table: only entries below r_run_count are ever looked at
    t_id r_run_color [RUN_SLOTS];
    t_id r_run_depth [RUN_SLOTS];
    logic              run_we;

    // RAM ports
    logic               samp_we;
    t_id                samp_wdata;
    logic [SAMP_AW-1:0] samp_waddr;
    t_id                samp_rdata;
    logic               rec_we;
    logic [REC_W-1:0]   rec_rdata;

    logic accept;
    t_id  ent_c, ent_d;
    logic ent_tp, ent_match, ent_att;
    logic samp_rtds, pal_have, emit_issue;
    logic [SUM_W-1:0] vsum, isum;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // per-entry compares for the run-table walk
    assign ent_c     = r_run_color[r_ridx[RUN_AW-1:0]];
    assign ent_d     = r_run_depth[r_ridx[RUN_AW-1:0]];
    assign ent_tp    = ((r_tex != '0) && ((ent_c == r_tex) || (ent_d == r_tex)))
                    || ((r_pal != '0) && ((ent_c == r_pal) || (ent_d == r_pal)));
    assign ent_match = (ent_c == r_rt) && (ent_d == r_ds);
    assign ent_att   = (ent_c == r_rt) || (ent_d == r_rt)
                    || ((r_ds != '0) && ((ent_c == r_ds) || (ent_d == r_ds)));

    assign samp_rtds = (samp_rdata == r_rt) || ((r_ds != '0) && (samp_rdata == r_ds));
    // palette counts as present if the texture just noted is the same id
    assign pal_have  = (r_pal == '0) || r_flags.samp_pal || (r_pal == r_tex);

    assign vsum = SUM_W'(r_vtot) + SUM_W'(r_nv);
    assign isum = SUM_W'(r_itot) + SUM_W'(r_ni);

    assign emit_issue = (r_ridx < r_run_count) && (r_didx < r_q_count);

    always_comb begin
        n_state      = r_state;
        n_ridx       = r_ridx;
        n_sidx       = r_sidx;
        n_didx       = r_didx;
        n_pend       = r_pend;
        n_pend_run   = r_pend_run;
        n_flags      = r_flags;
        n_run_sel    = r_run_sel;
        n_run_count  = r_run_count;
        n_samp_count = r_samp_count;
        n_q_count    = r_q_count;
        n_vtot       = r_vtot;
        n_itot       = r_itot;
        n_vbudget    = r_vbudget;
        n_ibudget    = r_ibudget;
        n_strobe     = 1'b0;
        n_kind       = KIND_QUEUED;
        n_tag_out    = '0;
        n_run_out    = '0;
        n_last       = 1'b0;
        run_we       = 1'b0;
        samp_we      = 1'b0;
        samp_waddr   = r_samp_count[SAMP_AW-1:0];
        samp_wdata   = r_tex;
        rec_we       = 1'b0;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_VERTEX_BUDGET) begin
                n_vbudget = i_cfg_data;
            end else begin
                n_ibudget = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_flags = '0;
                    n_ridx  = '0;
                    n_sidx  = '0;
                    n_didx  = '0;
                    n_pend  = 1'b0;
                    unique case (i_action)
                        ACT_ENQUEUE: begin
                            if (i_color_target == '0) begin
                                // no colour target: refuse outright, state untouched
                                n_strobe = 1'b1;
                                n_kind   = KIND_FLUSH;
                                n_last   = 1'b1;
                            end else begin
                                n_state = S_RUNS;
                            end
                        end
                        ACT_EMIT: begin
                            n_state = S_EMIT;
                        end
                        default: begin
                            // clear, and the unused action code with it
                            n_run_count  = '0;
                            n_samp_count = '0;
                            n_q_count    = '0;
                            n_vtot       = '0;
                            n_itot       = '0;
                            n_strobe     = 1'b1;
                            n_kind       = KIND_DONE;
                            n_last       = 1'b1;
                        end
                    endcase
                end
            end
            S_RUNS: begin
                if (r_ridx < r_run_count) begin
                    n_flags.hazard = r_flags.hazard || ent_tp;
                    n_flags.att    = r_flags.att || ent_att;
                    if (!r_flags.found && ent_match) begin
                        n_flags.found = 1'b1;
                        n_run_sel     = r_ridx[RUN_AW-1:0];
                    end
                    n_ridx = r_ridx + RUN_CW'(1);
                end else begin
                    n_state = S_SAMP;
                end
            end
            S_SAMP: begin
                // read issued, compared once the registered data returns
                if (r_pend) begin
                    n_flags.samp_rtds = r_flags.samp_rtds || samp_rtds;
                    n_flags.samp_tex  = r_flags.samp_tex || (samp_rdata == r_tex);
                    n_flags.samp_pal  = r_flags.samp_pal || (samp_rdata == r_pal);
                end
                if (r_sidx < r_samp_count) begin
                    n_pend = 1'b1;
                    n_sidx = r_sidx + SAMP_CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                if (r_flags.hazard || r_flags.samp_rtds) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_FLUSH;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else if (!r_flags.found && ((r_run_count >= RUN_FULL) || r_flags.att)) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_FLUSH;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (!r_flags.found) begin
                        // new run stays even if a later check refuses the draw
                        run_we      = 1'b1;
                        n_run_sel   = r_run_count[RUN_AW-1:0];
                        n_run_count = r_run_count + RUN_CW'(1);
                    end
                    if (r_q_count >= DRAW_FULL) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_FLUSH;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_VTX;
                    end
                end
            end
            S_VTX: begin
                if (vsum > SUM_W'(r_vbudget)) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_FLUSH;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                if (isum > SUM_W'(r_ibudget)) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_FLUSH;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_TEX;
                end
            end
            S_TEX: begin
                if ((r_tex != '0) && !r_flags.samp_tex) begin
                    if (r_samp_count >= SAMP_FULL) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_FLUSH;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        samp_we      = 1'b1;
                        n_samp_count = r_samp_count + SAMP_CW'(1);
                        n_state      = S_PAL;
                    end
                end else begin
                    n_state = S_PAL;
                end
            end
            S_PAL: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_state  = S_IDLE;
                if (!pal_have && (r_samp_count >= SAMP_FULL)) begin
                    // texture noted above stays noted
                    n_kind = KIND_FLUSH;
                end else begin
                    if (!pal_have) begin
                        samp_we      = 1'b1;
                        samp_wdata   = r_pal;
                        n_samp_count = r_samp_count + SAMP_CW'(1);
                    end
                    rec_we    = 1'b1;
                    n_q_count = r_q_count + DRAW_CW'(1);
                    n_vtot    = vsum[TOT_W-1:0];
                    n_itot    = isum[TOT_W-1:0];
                    n_kind    = KIND_QUEUED;
                end
            end
            S_EMIT: begin
                if (r_pend && (rec_rdata[RUN_AW-1:0] == r_pend_run)) begin
                    n_strobe  = 1'b1;
                    n_kind    = KIND_EMIT;
                    n_tag_out = rec_rdata[RUN_AW +: ID_W];
                    n_run_out = RUNO_W'(r_pend_run);
                end
                if (emit_issue) begin
                    n_pend     = 1'b1;
                    n_pend_run = r_ridx[RUN_AW-1:0];
                    if ((r_didx + DRAW_CW'(1)) == r_q_count) begin
                        n_didx = '0;
                        n_ridx = r_ridx + RUN_CW'(1);
                    end else begin
                        n_didx = r_didx + DRAW_CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_run_count  = '0;
                        n_samp_count = '0;
                        n_q_count    = '0;
                        n_vtot       = '0;
                        n_itot       = '0;
                        n_strobe     = 1'b1;
                        n_kind       = KIND_DONE;
                        n_last       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ridx       <= '0;
            r_sidx       <= '0;
            r_didx       <= '0;
            r_pend       <= 1'b0;
            r_pend_run   <= '0;
            r_flags      <= '0;
            r_run_sel    <= '0;
            r_run_count  <= '0;
            r_samp_count <= '0;
            r_q_count    <= '0;
            r_vtot       <= '0;
            r_itot       <= '0;
            r_vbudget    <= VERTEX_BUDGET_RST;
            r_ibudget    <= INDEX_BUDGET_RST;
            r_strobe     <= 1'b0;
            r_kind       <= KIND_QUEUED;
            r_tag_out    <= '0;
            r_run_out    <= '0;
            r_last       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ridx       <= n_ridx;
            r_sidx       <= n_sidx;
            r_didx       <= n_didx;
            r_pend       <= n_pend;
            r_pend_run   <= n_pend_run;
            r_flags      <= n_flags;
            r_run_sel    <= n_run_sel;
            r_run_count  <= n_run_count;
            r_samp_count <= n_samp_count;
            r_q_count    <= n_q_count;
            r_vtot       <= n_vtot;
            r_itot       <= n_itot;
            r_vbudget    <= n_vbudget;
            r_ibudget    <= n_ibudget;
            r_strobe     <= n_strobe;
            r_kind       <= n_kind;
            r_tag_out    <= n_tag_out;
            r_run_out    <= n_run_out;
            r_last       <= n_last;
        end
    end

    // command word and run table (payload)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag <= i_draw_tag;
            r_rt  <= i_color_target;
            r_ds  <= i_depth_target;
            r_tex <= i_texture_id;
            r_pal <= i_palette_id;
            r_nv  <= i_vertex_count;
            r_ni  <= i_index_count;
        end
        if (run_we) begin
            r_run_color[r_run_count[RUN_AW-1:0]] <= r_rt;
            r_run_depth[r_run_count[RUN_AW-1:0]] <= r_ds;
        end
    end

    rpbht_ram #(
        .WIDTH (ID_W),
        .DEPTH (SAMPLED_SLOTS)
    ) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (samp_we),
        .i_waddr (samp_waddr),
        .i_wdata (samp_wdata),
        .i_raddr (r_sidx[SAMP_AW-1:0]),
        .o_rdata (samp_rdata)
    );

    // draw records: tag above, run index below
    rpbht_ram #(
        .WIDTH (REC_W),
        .DEPTH (DRAW_SLOTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_q_count[DRAW_AW-1:0]),
        .i_wdata ({r_tag, r_run_sel}),
        .i_raddr (r_didx[DRAW_AW-1:0]),
        .o_rdata (rec_rdata)
    );

    assign o_strobe  = r_strobe;
    assign o_kind    = r_kind;
    assign o_out_tag = r_tag_out;
    assign o_out_run = r_run_out;
    assign o_last    = r_last;

    // table fill levels never pass their capacity
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= RUN_FULL)
        else $error("run count beyond table");
    a_samp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_samp_count <= SAMP_FULL)
        else $error("sampled count beyond set");
    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= DRAW_FULL)
        else $error("queued count beyond draw table");
    // the closing word of a command coincides with the sequencer going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("last word while still busy");
    // an accepted command either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("command accepted but dropped");
    a_emit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_EMIT)) |-> !o_last)
        else $error("emitted draw flagged last");

endmodule
`default_nettype wire
